>>> hdl/nd_strided_copy_address_gen_unit_assert.svh
// Assertion macros shared by the address generator RTL.
`ifndef ND_STRIDED_COPY_ADDRESS_GEN_UNIT_ASSERT_SVH
`define ND_STRIDED_COPY_ADDRESS_GEN_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NSC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("address generator assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define NSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("address generator assertion failed");

`endif

>>> hdl/nsc_pkg.sv
// Types and constants for the strided copy address generator.
package nsc_pkg;

    localparam int MAX_DIMS   = 8;
    localparam int DIM_W      = 3;
    localparam int DCNT_W     = 4;
    localparam int ADDR_BITS  = 48;
    localparam int EXT_BITS   = 32;
    localparam int LEN_BITS   = 40;
    localparam int IB_W       = 8;
    localparam int CFG_W      = 48;
    localparam int MUL_A_W    = 64;
    localparam int MUL_B_W    = 33;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W  = 6;

    // Function codes of an input transaction.
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_NEXT  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;
    localparam logic [1:0] ST_ACK  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DIM_COUNT  = 2'd0;
    localparam logic [1:0] CFG_ITEM_BYTES = 2'd1;
    localparam logic [1:0] CFG_SRC_BASE   = 2'd2;
    localparam logic [1:0] CFG_DST_BASE   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_CHKD,
        S_STR,
        S_OP,
        S_MUL,
        S_FIN,
        S_ODO,
        S_EMIT
    } state_t;

    // Multiplier operations issued by the start sequencer.
    typedef enum logic [3:0] {
        OP_SSTR,
        OP_DSTR,
        OP_SBS,
        OP_SB,
        OP_SWR,
        OP_SMX,
        OP_DBS,
        OP_DB,
        OP_DWR,
        OP_DMX,
        OP_LEN,
        OP_SL,
        OP_DL
    } op_t;

endpackage

>>> hdl/nd_strided_copy_address_gen_unit.sv
// Address generator for N-dimensional strided block copies.
// Usage: the input channel (in_valid/in_ready) carries a function code and a
// dimension descriptor. A load transaction stores one dimension's descriptor,
// a start transaction derives strides and base offsets, and each next
// transaction returns one contiguous run on the output channel
// (out_valid/out_ready): byte addresses, run length, last flag and status.
// Every input transaction gives exactly one result transaction.
// A start transaction checks the source range of each dimension in use; unless
// one is empty or inverted, it then runs a shared bit-serial 64 by 33
// multiplier (operand load, 33 shifts, collect): 2 products per outer
// dimension for the strides, 9 per dimension for offsets and bounds and 2 for
// the final bounds. A next transaction on an active copy with more than one
// dimension in use steps the odometer outward past each dimension that wraps.
// One transaction at a time; in_ready is high only while the block is idle.
// Reset clears the sequencer, the odometer and the output valid flag; loaded
// descriptors are undefined until written. When the receiver stalls, the
// result stays in the output register and the next result waits behind it.
module nd_strided_copy_address_gen_unit
    import nsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            func,
    input  logic [DIM_W-1:0]      dim_index,
    input  logic [EXT_BITS-1:0]   src_extent,
    input  logic [EXT_BITS-1:0]   dst_extent,
    input  logic [EXT_BITS-1:0]   src_first,
    input  logic [EXT_BITS-1:0]   src_end,
    input  logic [EXT_BITS-1:0]   dst_first,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ADDR_BITS-1:0]  src_addr,
    output logic [ADDR_BITS-1:0]  dst_addr,
    output logic [LEN_BITS-1:0]   chunk_bytes,
    output logic                  last,
    output logic [1:0]            status
);

    `include "nd_strided_copy_address_gen_unit_assert.svh"

    // Configuration registers.
    logic [DCNT_W-1:0]    dim_count_reg;
    logic [IB_W-1:0]      item_bytes_reg;
    logic [ADDR_BITS-1:0] src_base_reg;
    logic [ADDR_BITS-1:0] dst_base_reg;

    // Descriptor tables and derived per-dimension tables.
    logic [EXT_BITS-1:0]  src_ext_tab   [MAX_DIMS];
    logic [EXT_BITS-1:0]  dst_ext_tab   [MAX_DIMS];
    logic [EXT_BITS-1:0]  src_first_tab [MAX_DIMS];
    logic [EXT_BITS-1:0]  src_end_tab   [MAX_DIMS];
    logic [EXT_BITS-1:0]  dst_first_tab [MAX_DIMS];
    logic [ADDR_BITS-1:0] src_str_tab   [MAX_DIMS];
    logic [ADDR_BITS-1:0] dst_str_tab   [MAX_DIMS];
    logic [ADDR_BITS-1:0] src_bstr_tab  [MAX_DIMS];
    logic [ADDR_BITS-1:0] dst_bstr_tab  [MAX_DIMS];
    logic [ADDR_BITS-1:0] src_wrap_tab  [MAX_DIMS];
    logic [ADDR_BITS-1:0] dst_wrap_tab  [MAX_DIMS];
    logic [EXT_BITS-1:0]  cnt_tab       [MAX_DIMS];

    // Sequencer and working registers.
    state_t               state_reg, state_next;
    op_t                  op_reg;
    logic [DIM_W-1:0]     idx_reg;
    logic                 copy_active_reg;
    logic                 bad_reg;
    logic                 empty_reg;
    logic                 ovf_reg;
    logic [ADDR_BITS:0]   s_reg;
    logic [ADDR_BITS:0]   d_reg;
    logic [ADDR_BITS-1:0] sb_reg;
    logic [ADDR_BITS-1:0] db_reg;
    logic [MUL_A_W-1:0]   smax_reg;
    logic [MUL_A_W-1:0]   dmax_reg;
    logic [ADDR_BITS-1:0] run_s_reg;
    logic [ADDR_BITS-1:0] run_d_reg;
    logic [ADDR_BITS-1:0] cur_s_reg;
    logic [ADDR_BITS-1:0] cur_d_reg;
    logic [LEN_BITS-1:0]  len_reg;

    // Shared multiplier.
    logic [MUL_P_W-1:0]   mul_acc_reg;
    logic [MUL_P_W-1:0]   mul_a_reg;
    logic [MUL_B_W-1:0]   mul_b_reg;
    logic [MUL_CNT_W-1:0] mul_cnt_reg;

    // Pending result and output register.
    logic [ADDR_BITS-1:0] res_src_reg;
    logic [ADDR_BITS-1:0] res_dst_reg;
    logic [LEN_BITS-1:0]  res_len_reg;
    logic                 res_last_reg;
    logic [1:0]           res_status_reg;
    logic                 out_valid_reg;
    logic [ADDR_BITS-1:0] out_src_reg;
    logic [ADDR_BITS-1:0] out_dst_reg;
    logic [LEN_BITS-1:0]  out_len_reg;
    logic                 out_last_reg;
    logic [1:0]           out_status_reg;

    // Combinational helpers.
    logic [DCNT_W-1:0]    dims_n;
    logic [DIM_W-1:0]     last_idx;
    logic                 in_accept;
    logic                 slot_free;
    logic [EXT_BITS-1:0]  shape_w;
    logic [EXT_BITS-1:0]  span_w;
    logic [EXT_BITS-1:0]  endm1_w;
    logic [MUL_B_W-1:0]   dspan_w;
    logic [MUL_A_W-1:0]   mul_a_sel;
    logic [MUL_B_W-1:0]   mul_b_sel;
    logic [ADDR_BITS:0]   prod_sat;
    logic [MUL_A_W:0]     smax_sum;
    logic [MUL_A_W:0]     dmax_sum;
    logic [IB_W-1:0]      tail_w;
    logic [ADDR_BITS+1:0] sl_sum;
    logic [ADDR_BITS+1:0] dl_sum;
    logic                 bound_ovf;
    logic [EXT_BITS:0]    cnt_inc;
    logic                 odo_carry;
    logic                 out_clear;

    // Dimensions in use, clamped to the supported range.
    always_comb
    begin
        if (dim_count_reg == '0)
            dims_n = DCNT_W'(1);
        else if (dim_count_reg > DCNT_W'(MAX_DIMS))
            dims_n = DCNT_W'(MAX_DIMS);
        else
            dims_n = dim_count_reg;
        last_idx = DIM_W'(dims_n - DCNT_W'(1));
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Descriptor terms of the dimension under the sequencer index.
    assign shape_w = src_end_tab[idx_reg] - src_first_tab[idx_reg];
    assign span_w  = shape_w - EXT_BITS'(1);
    assign endm1_w = src_end_tab[idx_reg] - EXT_BITS'(1);
    assign dspan_w = {1'b0, dst_first_tab[idx_reg]} + {1'b0, span_w};

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a_sel = '0;
        mul_b_sel = '0;
        case (op_reg)
            OP_SSTR:
            begin
                mul_a_sel = MUL_A_W'(s_reg);
                mul_b_sel = MUL_B_W'(src_ext_tab[idx_reg]);
            end
            OP_DSTR:
            begin
                mul_a_sel = MUL_A_W'(d_reg);
                mul_b_sel = MUL_B_W'(dst_ext_tab[idx_reg]);
            end
            OP_SBS:
            begin
                mul_a_sel = MUL_A_W'(src_str_tab[idx_reg]);
                mul_b_sel = MUL_B_W'(item_bytes_reg);
            end
            OP_SB:
            begin
                mul_a_sel = MUL_A_W'(src_bstr_tab[idx_reg]);
                mul_b_sel = MUL_B_W'(src_first_tab[idx_reg]);
            end
            OP_SWR:
            begin
                mul_a_sel = MUL_A_W'(src_bstr_tab[idx_reg]);
                mul_b_sel = MUL_B_W'(span_w);
            end
            OP_SMX:
            begin
                mul_a_sel = MUL_A_W'(src_str_tab[idx_reg]);
                mul_b_sel = MUL_B_W'(endm1_w);
            end
            OP_DBS:
            begin
                mul_a_sel = MUL_A_W'(dst_str_tab[idx_reg]);
                mul_b_sel = MUL_B_W'(item_bytes_reg);
            end
            OP_DB:
            begin
                mul_a_sel = MUL_A_W'(dst_bstr_tab[idx_reg]);
                mul_b_sel = MUL_B_W'(dst_first_tab[idx_reg]);
            end
            OP_DWR:
            begin
                mul_a_sel = MUL_A_W'(dst_bstr_tab[idx_reg]);
                mul_b_sel = MUL_B_W'(span_w);
            end
            OP_DMX:
            begin
                mul_a_sel = MUL_A_W'(dst_str_tab[idx_reg]);
                mul_b_sel = dspan_w;
            end
            OP_LEN:
            begin
                mul_a_sel = MUL_A_W'(shape_w);
                mul_b_sel = MUL_B_W'(item_bytes_reg);
            end
            OP_SL:
            begin
                mul_a_sel = smax_reg;
                mul_b_sel = MUL_B_W'(item_bytes_reg);
            end
            OP_DL:
            begin
                mul_a_sel = dmax_reg;
                mul_b_sel = MUL_B_W'(item_bytes_reg);
            end
            default:
            begin
                mul_a_sel = '0;
                mul_b_sel = '0;
            end
        endcase
    end

    // Product post-processing: saturation, bound sums and overflow tests.
    always_comb
    begin
        if (|mul_acc_reg[MUL_P_W-1:ADDR_BITS])
            prod_sat = {1'b1, {ADDR_BITS{1'b0}}};
        else
            prod_sat = {1'b0, mul_acc_reg[ADDR_BITS-1:0]};
        smax_sum = {1'b0, smax_reg} + {1'b0, mul_acc_reg[MUL_A_W-1:0]};
        dmax_sum = {1'b0, dmax_reg} + {1'b0, mul_acc_reg[MUL_A_W-1:0]};
        tail_w   = (item_bytes_reg == '0) ? '0 : item_bytes_reg - IB_W'(1);
        sl_sum   = (ADDR_BITS+2)'(src_base_reg) + (ADDR_BITS+2)'(mul_acc_reg[ADDR_BITS-1:0])
                 + (ADDR_BITS+2)'(tail_w);
        dl_sum   = (ADDR_BITS+2)'(dst_base_reg) + (ADDR_BITS+2)'(mul_acc_reg[ADDR_BITS-1:0])
                 + (ADDR_BITS+2)'(tail_w);
        if (op_reg == OP_SL)
            bound_ovf = (|mul_acc_reg[MUL_P_W-1:ADDR_BITS]) || (|sl_sum[ADDR_BITS+1:ADDR_BITS]);
        else
            bound_ovf = (|mul_acc_reg[MUL_P_W-1:ADDR_BITS]) || (|dl_sum[ADDR_BITS+1:ADDR_BITS]);
    end

    // Odometer step for the dimension under the sequencer index.
    assign cnt_inc   = {1'b0, cnt_tab[idx_reg]} + (EXT_BITS+1)'(1);
    assign odo_carry = !(cnt_inc < {1'b0, shape_w});

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (func == FUNC_START)
                        state_next = S_CHK;
                    else if ((func == FUNC_NEXT) && copy_active_reg && (dims_n != DCNT_W'(1)))
                        state_next = S_ODO;
                    else
                        state_next = S_EMIT;
                end
            end
            S_CHK:
            begin
                if (idx_reg == last_idx)
                    state_next = S_CHKD;
            end
            S_CHKD:
            begin
                if (bad_reg || empty_reg)
                    state_next = S_EMIT;
                else
                    state_next = S_STR;
            end
            S_STR:
                state_next = S_OP;
            S_OP:
                state_next = S_MUL;
            S_MUL:
            begin
                if (mul_cnt_reg == '0)
                begin
                    if (op_reg == OP_DSTR)
                        state_next = S_STR;
                    else if (op_reg == OP_DL)
                        state_next = S_FIN;
                    else
                        state_next = S_OP;
                end
            end
            S_FIN:
                state_next = S_EMIT;
            S_ODO:
            begin
                if (!odo_carry || (idx_reg == '0))
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control registers: configuration, copy flag, odometer and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg   <= DCNT_W'(1);
            item_bytes_reg  <= IB_W'(1);
            src_base_reg    <= '0;
            dst_base_reg    <= '0;
            copy_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int k = 0; k < MAX_DIMS; k++)
                cnt_tab[k] <= '0;
        end
        else
        begin
            // Configuration writes abort a copy in progress.
            if (cfg_wr_en)
            begin
                copy_active_reg <= 1'b0;
                case (cfg_index)
                    CFG_DIM_COUNT:  dim_count_reg  <= cfg_data[DCNT_W-1:0];
                    CFG_ITEM_BYTES: item_bytes_reg <= cfg_data[IB_W-1:0];
                    CFG_SRC_BASE:   src_base_reg   <= cfg_data[ADDR_BITS-1:0];
                    CFG_DST_BASE:   dst_base_reg   <= cfg_data[ADDR_BITS-1:0];
                    default:        copy_active_reg <= 1'b0;
                endcase
            end

            if (state_reg == S_IDLE && in_accept)
            begin
                if ((func == FUNC_LOAD) || (func == FUNC_START))
                    copy_active_reg <= 1'b0;
                else if ((func == FUNC_NEXT) && (dims_n == DCNT_W'(1)))
                    copy_active_reg <= 1'b0;
            end

            if (state_reg == S_FIN && !ovf_reg)
            begin
                copy_active_reg <= 1'b1;
                for (int k = 0; k < MAX_DIMS; k++)
                    cnt_tab[k] <= '0;
            end

            if (state_reg == S_ODO)
            begin
                if (!odo_carry)
                    cnt_tab[idx_reg] <= cnt_inc[EXT_BITS-1:0];
                else
                begin
                    cnt_tab[idx_reg] <= '0;
                    if (idx_reg == '0)
                        copy_active_reg <= 1'b0;
                end
            end

            if (state_reg == S_EMIT && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Sequencer working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg      <= OP_SSTR;
            idx_reg     <= '0;
            mul_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                        idx_reg <= (func == FUNC_START) ? '0 : last_idx - DIM_W'(1);
                end
                S_CHK:
                begin
                    if (idx_reg != last_idx)
                        idx_reg <= idx_reg + DIM_W'(1);
                end
                S_CHKD:
                    idx_reg <= last_idx;
                S_STR:
                    op_reg <= (idx_reg == '0) ? OP_SBS : OP_SSTR;
                S_OP:
                    mul_cnt_reg <= MUL_CNT_W'(MUL_B_W);
                S_MUL:
                begin
                    if (mul_cnt_reg != '0)
                        mul_cnt_reg <= mul_cnt_reg - MUL_CNT_W'(1);
                    else
                    begin
                        case (op_reg)
                            OP_SSTR: op_reg <= OP_DSTR;
                            OP_DSTR: idx_reg <= idx_reg - DIM_W'(1);
                            OP_SBS:  op_reg <= OP_SB;
                            OP_SB:   op_reg <= OP_SWR;
                            OP_SWR:  op_reg <= OP_SMX;
                            OP_SMX:  op_reg <= OP_DBS;
                            OP_DBS:  op_reg <= OP_DB;
                            OP_DB:   op_reg <= OP_DWR;
                            OP_DWR:  op_reg <= OP_DMX;
                            OP_DMX:  op_reg <= OP_LEN;
                            OP_LEN:
                            begin
                                if (idx_reg == last_idx)
                                    op_reg <= OP_SL;
                                else
                                begin
                                    op_reg  <= OP_SBS;
                                    idx_reg <= idx_reg + DIM_W'(1);
                                end
                            end
                            OP_SL:   op_reg <= OP_DL;
                            default: op_reg <= OP_SSTR;
                        endcase
                    end
                end
                S_ODO:
                begin
                    if (odo_carry && (idx_reg != '0))
                        idx_reg <= idx_reg - DIM_W'(1);
                end
                default:
                    idx_reg <= idx_reg;
            endcase
        end
    end

    // Datapath: tables, shared multiplier, accumulators and results.
    always_ff @(posedge clk)
    begin
        // Descriptor loads.
        if (state_reg == S_IDLE && in_accept && func == FUNC_LOAD)
        begin
            src_ext_tab[dim_index]   <= src_extent;
            dst_ext_tab[dim_index]   <= dst_extent;
            src_first_tab[dim_index] <= src_first;
            src_end_tab[dim_index]   <= src_end;
            dst_first_tab[dim_index] <= dst_first;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_src_reg  <= '0;
                    res_dst_reg  <= '0;
                    res_len_reg  <= '0;
                    res_last_reg <= 1'b0;
                    bad_reg      <= 1'b0;
                    empty_reg    <= 1'b0;
                    if (func == FUNC_LOAD)
                        res_status_reg <= ST_ACK;
                    else if (func == FUNC_NEXT && copy_active_reg)
                    begin
                        res_src_reg    <= run_s_reg + cur_s_reg;
                        res_dst_reg    <= run_d_reg + cur_d_reg;
                        res_len_reg    <= len_reg;
                        res_last_reg   <= (dims_n == DCNT_W'(1));
                        res_status_reg <= ST_OK;
                    end
                    else
                        res_status_reg <= ST_NONE;
                end
            end
            S_CHK:
            begin
                if (src_end_tab[idx_reg] < src_first_tab[idx_reg])
                    bad_reg <= 1'b1;
                else if (src_end_tab[idx_reg] == src_first_tab[idx_reg])
                    empty_reg <= 1'b1;
            end
            S_CHKD:
            begin
                res_status_reg <= bad_reg ? ST_ERR : ST_NONE;
                s_reg    <= (ADDR_BITS+1)'(1);
                d_reg    <= (ADDR_BITS+1)'(1);
                sb_reg   <= '0;
                db_reg   <= '0;
                smax_reg <= '0;
                dmax_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            S_STR:
            begin
                // Stride of this dimension is the product of the inner extents.
                src_str_tab[idx_reg] <= s_reg[ADDR_BITS-1:0];
                dst_str_tab[idx_reg] <= d_reg[ADDR_BITS-1:0];
                if (s_reg[ADDR_BITS] || d_reg[ADDR_BITS])
                    ovf_reg <= 1'b1;
            end
            S_OP:
            begin
                mul_acc_reg <= '0;
                mul_a_reg   <= MUL_P_W'(mul_a_sel);
                mul_b_reg   <= mul_b_sel;
            end
            S_MUL:
            begin
                if (mul_cnt_reg != '0)
                begin
                    // One multiplier bit per cycle, shift and add.
                    if (mul_b_reg[0])
                        mul_acc_reg <= mul_acc_reg + mul_a_reg;
                    mul_a_reg <= {mul_a_reg[MUL_P_W-2:0], 1'b0};
                    mul_b_reg <= {1'b0, mul_b_reg[MUL_B_W-1:1]};
                end
                else
                begin
                    case (op_reg)
                        OP_SSTR: s_reg <= prod_sat;
                        OP_DSTR: d_reg <= prod_sat;
                        OP_SBS:  src_bstr_tab[idx_reg] <= mul_acc_reg[ADDR_BITS-1:0];
                        OP_SB:   sb_reg <= sb_reg + mul_acc_reg[ADDR_BITS-1:0];
                        OP_SWR:  src_wrap_tab[idx_reg] <= mul_acc_reg[ADDR_BITS-1:0];
                        OP_SMX:
                        begin
                            smax_reg <= smax_sum[MUL_A_W-1:0];
                            if (smax_sum[MUL_A_W] || (|mul_acc_reg[MUL_P_W-1:MUL_A_W]))
                                ovf_reg <= 1'b1;
                        end
                        OP_DBS:  dst_bstr_tab[idx_reg] <= mul_acc_reg[ADDR_BITS-1:0];
                        OP_DB:   db_reg <= db_reg + mul_acc_reg[ADDR_BITS-1:0];
                        OP_DWR:  dst_wrap_tab[idx_reg] <= mul_acc_reg[ADDR_BITS-1:0];
                        OP_DMX:
                        begin
                            dmax_reg <= dmax_sum[MUL_A_W-1:0];
                            if (dmax_sum[MUL_A_W] || (|mul_acc_reg[MUL_P_W-1:MUL_A_W]))
                                ovf_reg <= 1'b1;
                        end
                        OP_LEN:
                        begin
                            if (idx_reg == last_idx)
                                len_reg <= mul_acc_reg[LEN_BITS-1:0];
                        end
                        default:
                        begin
                            // Last byte touched in either array must fit the address.
                            if (bound_ovf)
                                ovf_reg <= 1'b1;
                        end
                    endcase
                end
            end
            S_FIN:
            begin
                res_status_reg <= ovf_reg ? ST_ERR : ST_ACK;
                run_s_reg      <= src_base_reg + sb_reg;
                run_d_reg      <= dst_base_reg + db_reg;
                cur_s_reg      <= '0;
                cur_d_reg      <= '0;
            end
            S_ODO:
            begin
                if (!odo_carry)
                begin
                    cur_s_reg    <= cur_s_reg + src_bstr_tab[idx_reg];
                    cur_d_reg    <= cur_d_reg + dst_bstr_tab[idx_reg];
                    res_last_reg <= 1'b0;
                end
                else
                begin
                    cur_s_reg <= cur_s_reg - src_wrap_tab[idx_reg];
                    cur_d_reg <= cur_d_reg - dst_wrap_tab[idx_reg];
                    if (idx_reg == '0)
                        res_last_reg <= 1'b1;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_src_reg    <= res_src_reg;
                    out_dst_reg    <= res_dst_reg;
                    out_len_reg    <= res_len_reg;
                    out_last_reg   <= res_last_reg;
                    out_status_reg <= res_status_reg;
                end
            end
            default:
                res_status_reg <= res_status_reg;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign src_addr    = out_src_reg;
    assign dst_addr    = out_dst_reg;
    assign chunk_bytes = out_len_reg;
    assign last        = out_last_reg;
    assign status      = out_status_reg;

    // Addresses, length and last flag all clear.
    assign out_clear = (src_addr == '0) && (dst_addr == '0) && (chunk_bytes == '0) && !last;

    // A result without a run carries zero addresses, length and last.
    `NSC_ASSERT_SAME(a_nonrun_zero, out_valid && (status != ST_OK), out_clear)
    // The block is busy in the cycle after each accepted transaction.
    `NSC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // The odometer only steps while a copy is armed.
    `NSC_ASSERT_SAME(a_odo_active, state_reg == S_ODO, copy_active_reg)

endmodule

>>> test/testbench.sv
// Self-checking testbench for the N-dimensional strided copy address generator.
`timescale 1ns / 1ps

module testbench;
    import nsc_pkg::*;

    typedef struct {
        logic [1:0]          fn;
        logic [DIM_W-1:0]    dim;
        logic [EXT_BITS-1:0] sext;
        logic [EXT_BITS-1:0] dext;
        logic [EXT_BITS-1:0] sfirst;
        logic [EXT_BITS-1:0] send;
        logic [EXT_BITS-1:0] dfirst;
    } xfer_t;

    typedef struct {
        logic [ADDR_BITS-1:0] sa;
        logic [ADDR_BITS-1:0] da;
        logic [LEN_BITS-1:0]  len;
        logic                 lst;
        logic [1:0]           st;
    } chunk_t;

    localparam logic [63:0] AMASK = 64'hFFFF_FFFF_FFFF;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [1:0]           cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           func;
    logic [DIM_W-1:0]     dim_index;
    logic [EXT_BITS-1:0]  src_extent;
    logic [EXT_BITS-1:0]  dst_extent;
    logic [EXT_BITS-1:0]  src_first;
    logic [EXT_BITS-1:0]  src_end;
    logic [EXT_BITS-1:0]  dst_first;
    logic                 out_valid;
    logic                 out_ready;
    logic [ADDR_BITS-1:0] src_addr;
    logic [ADDR_BITS-1:0] dst_addr;
    logic [LEN_BITS-1:0]  chunk_bytes;
    logic                 last;
    logic [1:0]           status;

    // Pending stimulus, expected chunks and the error flag.
    xfer_t  pending_q[$];
    xfer_t  cur;
    chunk_t chunk_q[$];
    bit     failed;
    int     in_gap;
    int     out_gap;

    // Shadow copy of the block's registers and tables.
    logic [3:0]  m_dcount;
    logic [7:0]  m_ibytes;
    logic [63:0] m_sbase, m_dbase;
    logic [63:0] m_sext[MAX_DIMS], m_dext[MAX_DIMS], m_sfirst[MAX_DIMS];
    logic [63:0] m_send[MAX_DIMS], m_dfirst[MAX_DIMS];
    logic [63:0] m_sstride[MAX_DIMS], m_dstride[MAX_DIMS], m_idx[MAX_DIMS];
    logic [63:0] m_soff, m_doff;
    bit          m_active;

    nd_strided_copy_address_gen_unit DUT (.*);

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [63:0] mul_ck(input logic [63:0] a, input logic [63:0] b,
                                           inout bit ovf);
        if (a != 0 && b > 64'hFFFF_FFFF_FFFF_FFFF / a)
        begin
            ovf = 1'b1;
            return 64'd0;
        end
        return a * b;
    endfunction

    function automatic logic [63:0] add_ck(input logic [63:0] a, input logic [63:0] b,
                                           inout bit ovf);
        logic [63:0] s;
        s = a + b;
        if (s < a)
            ovf = 1'b1;
        return s;
    endfunction

    function automatic int dims_in_use();
        if (m_dcount < 1)
            return 1;
        if (m_dcount > MAX_DIMS)
            return MAX_DIMS;
        return m_dcount;
    endfunction

    // Start: strides, block offsets and bounds checks; returns the status.
    function automatic logic [1:0] start_status();
        int n;
        bit bad, empty, ovf;
        logic [63:0] s, d, sb, db, smax, dmax, ib, tail, sl, dl, span;
        n = dims_in_use();
        bad = 0; empty = 0; ovf = 0;
        s = 1; d = 1; sb = 0; db = 0; smax = 0; dmax = 0;
        ib = m_ibytes;
        m_active = 0;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            m_idx[i] = 0;
            m_sstride[i] = 0;
            m_dstride[i] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            if (m_send[i] < m_sfirst[i])
                bad = 1;
            else if (m_send[i] == m_sfirst[i])
                empty = 1;
        end
        if (bad)
            return ST_ERR;
        if (empty)
            return ST_NONE;
        for (int i = n - 1; i >= 0; i--)
        begin
            if (i + 1 < n)
            begin
                s = mul_ck(s, m_sext[i+1], ovf);
                d = mul_ck(d, m_dext[i+1], ovf);
            end
            if (s > AMASK || d > AMASK)
                ovf = 1;
            m_sstride[i] = s & AMASK;
            m_dstride[i] = d & AMASK;
        end
        for (int i = 0; i < n; i++)
        begin
            span = m_send[i] - m_sfirst[i] - 1;
            sb = add_ck(sb, mul_ck(m_sfirst[i], m_sstride[i], ovf), ovf);
            smax = add_ck(smax, mul_ck(m_send[i] - 1, m_sstride[i], ovf), ovf);
            db = add_ck(db, mul_ck(m_dfirst[i], m_dstride[i], ovf), ovf);
            dmax = add_ck(dmax, mul_ck(m_dfirst[i] + span, m_dstride[i], ovf), ovf);
        end
        tail = (ib != 0) ? ib - 1 : 64'd0;
        sl = add_ck(add_ck(m_sbase, mul_ck(smax, ib, ovf), ovf), tail, ovf);
        dl = add_ck(add_ck(m_dbase, mul_ck(dmax, ib, ovf), ovf), tail, ovf);
        if (ovf || sl > AMASK || dl > AMASK)
            return ST_ERR;
        m_soff = (m_sbase + sb * ib) & AMASK;
        m_doff = (m_dbase + db * ib) & AMASK;
        m_active = 1;
        return ST_ACK;
    endfunction

    // Expected chunk for one accepted input transaction.
    function automatic chunk_t predict_chunk(input xfer_t x);
        chunk_t r;
        int n;
        logic [63:0] so, dof, ib, shape;
        bit done;
        r = '{default: '0};
        r.st = ST_NONE;
        if (x.fn == FUNC_LOAD)
        begin
            m_sext[x.dim] = x.sext;
            m_dext[x.dim] = x.dext;
            m_sfirst[x.dim] = x.sfirst;
            m_send[x.dim] = x.send;
            m_dfirst[x.dim] = x.dfirst;
            m_active = 0;
            r.st = ST_ACK;
        end
        else if (x.fn == FUNC_START)
            r.st = start_status();
        else if (x.fn == FUNC_NEXT && m_active)
        begin
            n = dims_in_use();
            so = 0; dof = 0; ib = m_ibytes; done = 1;
            for (int i = 0; i + 1 < n; i++)
            begin
                so += m_idx[i] * m_sstride[i];
                dof += m_idx[i] * m_dstride[i];
            end
            r.len = LEN_BITS'((m_send[n-1] - m_sfirst[n-1]) * ib);
            for (int i = n - 2; i >= 0; i--)
            begin
                shape = m_send[i] - m_sfirst[i];
                m_idx[i]++;
                if (m_idx[i] < shape)
                begin
                    done = 0;
                    break;
                end
                m_idx[i] = 0;
            end
            if (done)
                m_active = 0;
            r.sa = ADDR_BITS'(m_soff + so * ib);
            r.da = ADDR_BITS'(m_doff + dof * ib);
            r.lst = done;
            r.st = ST_OK;
        end
        return r;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Driver: presents queued transactions and records the expected chunk on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                chunk_q.push_back(predict_chunk(cur));
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                cur = pending_q.pop_front();
                func <= cur.fn;
                dim_index <= cur.dim;
                src_extent <= cur.sext;
                dst_extent <= cur.dext;
                src_first <= cur.sfirst;
                src_end <= cur.send;
                dst_first <= cur.dfirst;
                in_valid <= 1'b1;
                in_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: checks every result transaction against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        chunk_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (chunk_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction, actual status %0d", $time, status);
                    failed = 1;
                end
                else
                begin
                    e = chunk_q.pop_front();
                    if (src_addr !== e.sa || dst_addr !== e.da || chunk_bytes !== e.len ||
                        last !== e.lst || status !== e.st)
                    begin
                        $display("%0t: mismatch expected %h %h %h %b %0d actual %h %h %h %b %0d",
                                 $time, e.sa, e.da, e.len, e.lst, e.st,
                                 src_addr, dst_addr, chunk_bytes, last, status);
                        failed = 1;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_gap = pick_gap();
                out_ready <= 1'b1;
            end
        end
    end

    function automatic xfer_t mk(input logic [1:0] f, input int d, input logic [31:0] se,
                                 input logic [31:0] de, input logic [31:0] sf,
                                 input logic [31:0] sn, input logic [31:0] df);
        xfer_t x;
        x.fn = f; x.dim = DIM_W'(d); x.sext = se; x.dext = de;
        x.sfirst = sf; x.send = sn; x.dfirst = df;
        return x;
    endfunction

    task automatic push(input xfer_t x);
        pending_q.push_back(x);
    endtask

    // Wait until every transaction has been accepted and answered.
    task automatic drain();
        while (pending_q.size() != 0 || in_valid || chunk_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [47:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_DIM_COUNT:  m_dcount = val[3:0];
            CFG_ITEM_BYTES: m_ibytes = val[7:0];
            CFG_SRC_BASE:   m_sbase = val;
            default:        m_dbase = val;
        endcase
        m_active = 0;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // One copy, mostly well-formed: descriptors, start and enough next transactions.
    task automatic gen_copy(input int n);
        int prod, shape, sf, df, hi, p;
        prod = 1;
        hi = (n > 4) ? 2 : 3;
        for (int d = 0; d < n; d++)
        begin
            shape = $urandom_range(1, hi);
            sf = $urandom_range(0, 5);
            df = $urandom_range(0, 5);
            p = $urandom_range(0, 99);
            if (p < 3)
                push(mk(FUNC_LOAD, d, $urandom, $urandom, $urandom, $urandom, $urandom));
            else if (p < 5)
                push(mk(FUNC_LOAD, d, 9, 9, sf + 1, sf, df));
            else if (p < 7)
                push(mk(FUNC_LOAD, d, 9, 9, sf, sf, df));
            else
                push(mk(FUNC_LOAD, d, sf + shape + $urandom_range(0, 3),
                        df + shape + $urandom_range(0, 3), sf, sf + shape, df));
            if (d < n - 1)
                prod *= shape;
        end
        push(mk(FUNC_START, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        for (int k = 0; k < prod + $urandom_range(0, 1); k++)
        begin
            if ($urandom_range(0, 99) < 2)
                push(mk(FUNC_LOAD, $urandom_range(n, 7), 4, 4, 0, 2, 0));
            push(mk(FUNC_NEXT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        end
    endtask

    task automatic gen_noise();
        push(mk($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom));
    endtask

    // Stimulus phases; configuration changes only between them.
    initial
    begin
        int dcs[8]  = '{1, 8, 2, 0, 3, 15, 4, 2};
        int ibs[8]  = '{1, 0, 255, 4, 7, 1, 2, 3};
        int budget;
        failed = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_data = '0;
        func = '0; dim_index = '0; src_extent = '0; dst_extent = '0;
        src_first = '0; src_end = '0; dst_first = '0;
        m_dcount = 1; m_ibytes = 1; m_sbase = 0; m_dbase = 0;
        m_soff = 0; m_doff = 0; m_active = 0;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            m_sext[i] = 0; m_dext[i] = 0; m_sfirst[i] = 0; m_send[i] = 0;
            m_dfirst[i] = 0; m_sstride[i] = 0; m_dstride[i] = 0; m_idx[i] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: no copy yet, unused code, extremes, error cases.
        push(mk(FUNC_NEXT, 0, 0, 0, 0, 0, 0));
        push(mk(2'd3, 7, '1, '1, '1, '1, '1));
        for (int d = 0; d < MAX_DIMS; d++)
            push(mk(FUNC_LOAD, d, 4, 5, 1, 3, 2));
        push(mk(FUNC_START, 0, 0, 0, 0, 0, 0));
        push(mk(FUNC_NEXT, 0, 0, 0, 0, 0, 0));
        push(mk(FUNC_NEXT, 0, 0, 0, 0, 0, 0));
        push(mk(FUNC_LOAD, 0, '1, '1, '1, '1, '1));
        push(mk(FUNC_START, 0, 0, 0, 0, 0, 0));
        push(mk(FUNC_LOAD, 0, 4, 4, 3, 2, 0));
        push(mk(FUNC_START, 0, 0, 0, 0, 0, 0));
        push(mk(FUNC_LOAD, 0, 4, 4, 2, 2, 0));
        push(mk(FUNC_START, 0, 0, 0, 0, 0, 0));
        push(mk(FUNC_LOAD, 0, '1, '1, 0, '1, 0));
        push(mk(FUNC_START, 0, 0, 0, 0, 0, 0));
        push(mk(FUNC_NEXT, 0, 0, 0, 0, 0, 0));
        push(mk(FUNC_LOAD, 0, 4, 4, 1, 3, 2));
        drain();

        // Random phases over several configurations.
        for (int ph = 0; ph < 8; ph++)
        begin
            cfg_write(CFG_DIM_COUNT, 48'(dcs[ph]));
            cfg_write(CFG_ITEM_BYTES, 48'(ibs[ph]));
            case (ph)
                1:       cfg_write(CFG_SRC_BASE, 48'hFFFF_FFFF_FFFF);
                2:       cfg_write(CFG_SRC_BASE, 48'h0);
                default: cfg_write(CFG_SRC_BASE, 48'({$urandom, $urandom}) & 48'h0FFF_FFFF_FFFF);
            endcase
            case (ph)
                3:       cfg_write(CFG_DST_BASE, 48'hFFFF_FFFF_FFFF);
                4:       cfg_write(CFG_DST_BASE, 48'h0);
                default: cfg_write(CFG_DST_BASE, 48'({$urandom, $urandom}) & 48'h0FFF_FFFF_FFFF);
            endcase
            budget = 115;
            while (budget > 0)
            begin
                int before_n;
                before_n = pending_q.size();
                if ($urandom_range(0, 99) < 85)
                    gen_copy(dims_in_use());
                else
                    gen_noise();
                budget -= pending_q.size() - before_n;
            end
            drain();
        end

        if (!failed)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
